FILE: sv/swt_pkg.sv
// Shared types and codes for the sliding window tracker.
// Holds the request and result codes and the result word layout.
// No dependencies.
package swt_pkg;

  typedef enum logic [2:0] {
    REQ_ACK    = 3'd0,
    REQ_DATA   = 3'd1,
    REQ_SYN    = 3'd2,
    REQ_SYNACK = 3'd3,
    REQ_SEND   = 3'd4,
    REQ_OPEN   = 3'd5
  } req_type_t;

  typedef enum logic [2:0] {
    KIND_DELIVER  = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_SYNACK   = 3'd2,
    KIND_SYN      = 3'd3,
    KIND_TRANSMIT = 3'd4,
    KIND_FREED    = 3'd5,
    KIND_FULL     = 3'd6
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRD,
    ST_DOUT,
    ST_MODW
  } state_t;

  localparam logic CFG_RESPONDER = 1'b0;
  localparam logic CFG_INITIATOR = 1'b1;

  localparam logic [31:0] RESPONDER_SEQ_RESET = 32'd500;
  localparam logic [31:0] INITIATOR_SEQ_RESET = 32'd1000;

  typedef struct packed {
    res_kind_t   kind;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] tag;
    logic [3:0]  count;
    logic        last;
  } res_t;

endpackage

FILE: sv/swt_mod.sv
// Remainder of a 32-bit sequence number by the reorder slot count.
// Reciprocal multiply; value, product, remainder registered. Uses swt_pkg.
module swt_mod import swt_pkg::*; #(
  parameter int RECV_SLOTS = 8,
  localparam int IW = (RECV_SLOTS > 1) ? $clog2(RECV_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   value,
  output logic          done,
  output logic [IW-1:0] rem
);

  localparam int SH = $clog2(RECV_SLOTS);
  localparam logic [63:0] DIV = 64'(RECV_SLOTS);
  localparam logic [63:0] POW = 64'd1 << (32 + SH);
  localparam logic [32:0] RECIP = 33'((POW + DIV - 64'd1) / DIV);
  localparam logic [IW-1:0] DIV_LOW = IW'(RECV_SLOTS);

  logic          v_mul;
  logic          v_sub;
  logic [31:0]   x;
  logic [64:0]   prod;
  logic [IW-1:0] x_low;
  logic [32:0]   quot;
  logic [IW-1:0] qd_low;
  logic [IW-1:0] r;

  assign quot   = 33'(prod >> (32 + SH));
  assign qd_low = quot[IW-1:0] * DIV_LOW;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul <= 1'b0;
      v_sub <= 1'b0;
      done  <= 1'b0;
    end else begin
      v_mul <= start;
      v_sub <= v_mul;
      done  <= v_sub;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= value;
    end
    if (v_mul) begin
      prod  <= 65'(x) * 65'(RECIP);
      x_low <= x[IW-1:0];
    end
    if (v_sub) begin
      r <= x_low - qd_low;
    end
  end

  assign rem = r;

endmodule

FILE: sv/swt_slot_ram.sv
// Reorder slot tag memory: one write port, one registered read port.
// Read data holds until the next read; depends on swt_pkg.
module swt_slot_ram import swt_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int DW = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/swt_out_reg.sv
// Output register for result words toward the master side.
// Loads a new word while the held one is taken; depends on swt_pkg.
module swt_out_reg import swt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t din,
  input  logic take,
  output logic free,
  output logic full,
  output res_t dout
);

  assign free = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

FILE: sv/sliding_window_tracker.sv
// Sliding window link tracker, top level.
// Uses swt_pkg, swt_mod, swt_slot_ram and swt_out_reg.
//
// One header event per word enters on the slave side; its type travels in
// s_tuser. Each event yields zero to RECV_SLOTS+1 result words on the master
// side, with m_tlast on the last word of the event and the kind in m_tuser.
// A simple event is accepted, then decided and loaded into the output
// register once it has room. A data word that fills the expected slot then
// drains the reorder memory in order, each delivered slot being read from
// the tag memory before it is emitted, followed by one ack word. Syn and
// syn-ack events then wait while the remainder unit finds the slot index
// of the new expected sequence. A new event is taken once the previous one
// is finished, even while its last result word still waits in the output
// register. A stalled receiver holds the block at the next word it wants to
// emit. Reset clears the sequence state and the slot valid bits, fills the
// send credits and restores the register defaults; the tag memory is not
// cleared. The user must write registers through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
module sliding_window_tracker import swt_pkg::*; #(
  parameter int RECV_SLOTS = 8,
  parameter int SEND_SLOTS = 8,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // seq_num [31:0], ack_num [63:32], payload_tag [79:64]
  input  logic [79:0] s_tdata,
  // req_type [2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // res_seq [31:0], res_ack [63:32], res_tag [79:64], res_count [83:80]
  output logic [87:0] m_tdata,
  // res_kind [2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (RECV_SLOTS > 1) ? $clog2(RECV_SLOTS) : 1;
  localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int CW = $clog2(SEND_SLOTS + 1);
  localparam logic [IW:0] RMOD = (IW + 1)'(RECV_SLOTS);
  localparam logic [IW-1:0] IDX_LAST = IW'(RECV_SLOTS - 1);
  localparam logic [CW-1:0] CREDIT_FULL = CW'(SEND_SLOTS);
  localparam logic [31:0] COUNT_CAP = (SEND_SLOTS < 15) ? 32'(SEND_SLOTS) : 32'd15;

  state_t state, state_next;

  req_type_t   req_q;
  logic [31:0] seq_q;
  logic [31:0] ack_q;
  logic [TW-1:0] tag_q;

  logic [31:0] cfg_resp;
  logic [31:0] cfg_init;

  logic [31:0] next_expected, next_expected_next;
  logic [31:0] last_acked, last_acked_next;
  logic [31:0] last_sent, last_sent_next;
  logic [CW-1:0] send_credit, send_credit_next;
  logic [IW-1:0] ne_idx, ne_idx_next;
  logic [RECV_SLOTS-1:0] recv_valid, recv_valid_next;

  logic s_accept;
  logic free;
  logic out_full;
  logic emit;
  res_t emit_res;
  res_t out_res;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic          ram_re;
  logic [TW-1:0] ram_rdata;

  logic          mod_start;
  logic          mod_done;
  logic [IW-1:0] mod_rem;

  logic [31:0] win_diff;
  logic        in_window;
  logic [IW:0] idx_sum;
  logic [IW-1:0] wr_idx;
  logic [31:0] ack_diff;
  logic [31:0] ack_span;
  logic        ack_ok;
  logic [31:0] freed;
  logic [CW-1:0] room;
  logic        slot_ready;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  assign win_diff  = seq_q - next_expected;
  assign in_window = win_diff < 32'(RECV_SLOTS);
  assign idx_sum   = {1'b0, ne_idx} + {1'b0, win_diff[IW-1:0]};
  assign wr_idx    = (idx_sum >= RMOD) ? IW'(idx_sum - RMOD) : idx_sum[IW-1:0];

  assign ack_diff = ack_q - (last_acked + 32'd1);
  assign ack_span = last_sent - last_acked + 32'd2;
  assign ack_ok   = ack_diff < ack_span;
  assign freed    = ack_q - last_acked;
  assign room     = CREDIT_FULL - send_credit;

  assign slot_ready = recv_valid[ne_idx];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (req_q)
          REQ_ACK: begin
            if (!ack_ok || free) state_next = ST_IDLE;
          end
          REQ_DATA: begin
            if (in_window && (seq_q == next_expected)) state_next = ST_DRD;
            else state_next = ST_IDLE;
          end
          REQ_SYN, REQ_SYNACK: begin
            if (free) state_next = ST_MODW;
          end
          REQ_SEND, REQ_OPEN: begin
            if (free) state_next = ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DRD: begin
        if (slot_ready) state_next = ST_DOUT;
        else if (free) state_next = ST_IDLE;
      end
      ST_DOUT: begin
        if (free) state_next = ST_DRD;
      end
      ST_MODW: begin
        if (mod_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    next_expected_next = next_expected;
    last_acked_next    = last_acked;
    last_sent_next     = last_sent;
    send_credit_next   = send_credit;
    ne_idx_next        = ne_idx;
    recv_valid_next    = recv_valid;
    emit      = 1'b0;
    emit_res  = '0;
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    ram_re    = 1'b0;
    mod_start = 1'b0;
    unique case (state)
      ST_EXEC: begin
        unique case (req_q)
          REQ_ACK: begin
            if (ack_ok && free) begin
              emit = 1'b1;
              emit_res.kind  = KIND_FREED;
              emit_res.count = (freed > COUNT_CAP) ? 4'(COUNT_CAP) : freed[3:0];
              emit_res.last  = 1'b1;
              last_acked_next = ack_q;
              send_credit_next = (freed >= 32'(room)) ? CREDIT_FULL :
                                 send_credit + freed[CW-1:0];
            end
          end
          REQ_DATA: begin
            if (in_window) begin
              ram_we = 1'b1;
              recv_valid_next[wr_idx] = 1'b1;
            end
          end
          REQ_SYN: begin
            if (free) begin
              emit = 1'b1;
              emit_res.kind = KIND_SYNACK;
              emit_res.seq  = cfg_resp;
              emit_res.ack  = seq_q + 32'd1;
              emit_res.last = 1'b1;
              next_expected_next = seq_q + 32'd1;
              last_sent_next = cfg_resp;
              mod_start = 1'b1;
            end
          end
          REQ_SYNACK: begin
            if (free) begin
              emit = 1'b1;
              emit_res.kind = KIND_ACK;
              emit_res.seq  = ack_q;
              emit_res.ack  = seq_q + 32'd1;
              emit_res.last = 1'b1;
              next_expected_next = seq_q + 32'd1;
              last_acked_next = ack_q;
              mod_start = 1'b1;
            end
          end
          REQ_SEND: begin
            if (free) begin
              emit = 1'b1;
              emit_res.last = 1'b1;
              if (send_credit == '0) begin
                emit_res.kind = KIND_FULL;
                emit_res.seq  = last_sent + 32'd1;
              end else begin
                emit_res.kind = KIND_TRANSMIT;
                emit_res.seq  = last_sent + 32'd1;
                emit_res.ack  = next_expected;
                emit_res.tag  = 16'(tag_q);
                last_sent_next   = last_sent + 32'd1;
                send_credit_next = send_credit - CW'(1);
              end
            end
          end
          REQ_OPEN: begin
            if (free) begin
              emit = 1'b1;
              emit_res.kind = KIND_SYN;
              emit_res.seq  = cfg_init;
              emit_res.last = 1'b1;
              last_sent_next = cfg_init;
            end
          end
          default: begin
          end
        endcase
      end
      ST_DRD: begin
        if (slot_ready) begin
          ram_re = 1'b1;
        end else if (free) begin
          emit = 1'b1;
          emit_res.kind = KIND_ACK;
          emit_res.seq  = seq_q;
          emit_res.ack  = next_expected;
          emit_res.last = 1'b1;
        end
      end
      ST_DOUT: begin
        if (free) begin
          emit = 1'b1;
          emit_res.kind = KIND_DELIVER;
          emit_res.seq  = next_expected;
          emit_res.tag  = 16'(ram_rdata);
          recv_valid_next[ne_idx] = 1'b0;
          next_expected_next = next_expected + 32'd1;
          ne_idx_next = (ne_idx == IDX_LAST) ? '0 : ne_idx + IW'(1);
        end
      end
      ST_MODW: begin
        if (mod_done) ne_idx_next = mod_rem;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      next_expected <= '0;
      last_acked    <= '0;
      last_sent     <= '0;
      send_credit   <= CREDIT_FULL;
      ne_idx        <= '0;
      recv_valid    <= '0;
      cfg_resp      <= RESPONDER_SEQ_RESET;
      cfg_init      <= INITIATOR_SEQ_RESET;
    end else begin
      state         <= state_next;
      next_expected <= next_expected_next;
      last_acked    <= last_acked_next;
      last_sent     <= last_sent_next;
      send_credit   <= send_credit_next;
      ne_idx        <= ne_idx_next;
      recv_valid    <= recv_valid_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RESPONDER: cfg_resp <= cfg_data;
          CFG_INITIATOR: cfg_init <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      req_q <= req_type_t'(s_tuser);
      seq_q <= s_tdata[31:0];
      ack_q <= s_tdata[63:32];
      tag_q <= s_tdata[64 +: TW];
    end
  end

  swt_slot_ram #(
    .DEPTH (RECV_SLOTS),
    .DW    (TW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tag_q),
    .re    (ram_re),
    .raddr (ne_idx),
    .rdata (ram_rdata)
  );

  swt_mod #(
    .RECV_SLOTS (RECV_SLOTS)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (seq_q + 32'd1),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  swt_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (emit),
    .din  (emit_res),
    .take (m_tready),
    .free (free),
    .full (out_full),
    .dout (out_res)
  );

  assign m_tvalid = out_full;
  assign m_tdata  = {4'b0, out_res.count, out_res.tag, out_res.ack, out_res.seq};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;

  a_deliver_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_DELIVER)) |-> !m_tlast)
    else $error("deliver word marked last");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    send_credit <= CREDIT_FULL)
    else $error("send credit above slot count");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    ne_idx <= IDX_LAST)
    else $error("expected slot index out of range");

  a_drain_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DOUT) |-> recv_valid[ne_idx])
    else $error("draining a slot that is not valid");

endmodule

FILE: verif/swt_checker.sv
// Checker for the sliding window tracker: watches the header, result and
// register ports, forecasts the result words of each accepted header event
// and compares them in order with what the block emits. Uses swt_pkg.
module swt_checker import swt_pkg::*; #(
  parameter int RECV_SLOTS = 8,
  parameter int SEND_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_CAP = (SEND_SLOTS < 15) ? SEND_SLOTS : 15;

  logic [31:0] resp_seq;
  logic [31:0] init_seq;
  logic [31:0] rx_next;
  logic [31:0] tx_acked;
  logic [31:0] tx_sent;
  logic [RECV_SLOTS-1:0] slot_valid;
  logic [15:0] slot_tag [RECV_SLOTS];
  int unsigned tx_credit;
  res_t awaited_words [$];

  function automatic res_t make_word(res_kind_t kind, logic [31:0] seq, logic [31:0] ack,
                                     logic [15:0] tag, logic [3:0] count);
    res_t w;
    w.kind = kind;
    w.seq = seq;
    w.ack = ack;
    w.tag = tag;
    w.count = count;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic string show_word(res_t w);
    return $sformatf("kind=%0d seq=%h ack=%h tag=%h count=%0d last=%b",
                     w.kind, w.seq, w.ack, w.tag, w.count, w.last);
  endfunction

  task automatic apply_header_event(input logic [2:0] rtype, input logic [31:0] seq,
                                    input logic [31:0] ack, input logic [15:0] tag);
    int first;
    int unsigned idx;
    logic [31:0] diff;
    logic [31:0] span;
    logic [31:0] freed;
    first = awaited_words.size();
    case (rtype)
      REQ_ACK: begin
        diff = ack - (tx_acked + 32'd1);
        span = tx_sent - tx_acked + 32'd2;
        if (diff < span) begin
          freed = ack - tx_acked;
          if (freed >= SEND_SLOTS - tx_credit) tx_credit = SEND_SLOTS;
          else tx_credit = tx_credit + freed;
          tx_acked = ack;
          awaited_words.push_back(make_word(KIND_FREED, '0, '0, '0,
                                  (freed > COUNT_CAP) ? 4'(COUNT_CAP) : freed[3:0]));
        end
      end
      REQ_DATA: begin
        diff = seq - rx_next;
        if (diff < RECV_SLOTS) begin
          idx = seq % RECV_SLOTS;
          slot_tag[idx] = tag;
          slot_valid[idx] = 1'b1;
          if (seq == rx_next) begin
            idx = rx_next % RECV_SLOTS;
            while (slot_valid[idx]) begin
              awaited_words.push_back(make_word(KIND_DELIVER, rx_next, '0, slot_tag[idx], '0));
              slot_valid[idx] = 1'b0;
              rx_next = rx_next + 32'd1;
              idx = rx_next % RECV_SLOTS;
            end
            awaited_words.push_back(make_word(KIND_ACK, seq, rx_next, '0, '0));
          end
        end
      end
      REQ_SYN: begin
        rx_next = seq + 32'd1;
        tx_sent = resp_seq;
        awaited_words.push_back(make_word(KIND_SYNACK, resp_seq, rx_next, '0, '0));
      end
      REQ_SYNACK: begin
        tx_acked = ack;
        rx_next = seq + 32'd1;
        awaited_words.push_back(make_word(KIND_ACK, ack, rx_next, '0, '0));
      end
      REQ_SEND: begin
        if (tx_credit == 0) begin
          awaited_words.push_back(make_word(KIND_FULL, tx_sent + 32'd1, '0, '0, '0));
        end else begin
          tx_sent = tx_sent + 32'd1;
          tx_credit = tx_credit - 1;
          awaited_words.push_back(make_word(KIND_TRANSMIT, tx_sent, rx_next, tag, '0));
        end
      end
      REQ_OPEN: begin
        tx_sent = init_seq;
        awaited_words.push_back(make_word(KIND_SYN, init_seq, '0, '0, '0));
      end
      default: begin
      end
    endcase
    if (awaited_words.size() > first) awaited_words[awaited_words.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (rst) begin
      resp_seq = RESPONDER_SEQ_RESET;
      init_seq = INITIATOR_SEQ_RESET;
      rx_next = '0;
      tx_acked = '0;
      tx_sent = '0;
      slot_valid = '0;
      tx_credit = SEND_SLOTS;
      awaited_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_RESPONDER) resp_seq = cfg_data;
        else init_seq = cfg_data;
      end
      if (s_tvalid && s_tready)
        apply_header_event(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[79:64]);
      if (m_tvalid && m_tready) begin
        got.kind = res_kind_t'(m_tuser);
        got.seq = m_tdata[31:0];
        got.ack = m_tdata[63:32];
        got.tag = m_tdata[79:64];
        got.count = m_tdata[83:80];
        got.last = m_tlast;
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %s", $time, show_word(got));
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_words.pop_front();
          if (got !== want || m_tdata[87:84] !== 4'd0) begin
            $display("%0t: result mismatch, expected %s, got %s (tdata %h)",
                     $time, show_word(want), show_word(got), m_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    words_due <= awaited_words.size();
  end

endmodule

FILE: verif/tb.sv
// Top of the sliding window tracker testbench: clock, reset, register writes
// and header stimulus with random idling on both sides; swt_checker does the
// comparison. Uses swt_pkg, sliding_window_tracker and swt_checker.
module tb import swt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RECV_SLOTS = 8;
  localparam int SEND_SLOTS = 8;
  localparam int TAG_BITS = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          words_due;

  int send_idle;
  int recv_idle = 0;
  int item_count;
  int cycle_count = 0;

  logic [31:0] resp_seq;
  logic [31:0] init_seq;
  logic [31:0] rx_next;
  logic [31:0] tx_acked;
  logic [31:0] tx_sent;
  int unsigned tx_credit;
  bit rx_sync;

  sliding_window_tracker #(
    .RECV_SLOTS(RECV_SLOTS),
    .SEND_SLOTS(SEND_SLOTS),
    .TAG_BITS(TAG_BITS)
  ) u_dut (.*);

  swt_checker #(
    .RECV_SLOTS(RECV_SLOTS),
    .SEND_SLOTS(SEND_SLOTS)
  ) u_checker (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_regs(input logic [31:0] resp, input logic [31:0] init);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RESPONDER;
    cfg_data <= resp;
    @(posedge clk);
    cfg_index <= CFG_INITIATOR;
    cfg_data <= init;
    @(posedge clk);
    cfg_we <= 1'b0;
    resp_seq = resp;
    init_seq = init;
  endtask

  // Sends one header word and keeps a rough view of the link for the
  // stimulus; data words leave rx_next to the caller.
  task automatic put_word(input logic [2:0] rtype, input logic [31:0] seq,
                          input logic [31:0] ack, input logic [15:0] tag);
    logic [31:0] freed;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {tag, ack, seq};
    s_tuser <= rtype;
    do @(posedge clk); while (!s_tready);
    if (rtype <= REQ_OPEN) item_count++;
    case (rtype)
      REQ_SYN: begin
        rx_next = seq + 32'd1;
        tx_sent = resp_seq;
      end
      REQ_SYNACK: begin
        rx_next = seq + 32'd1;
        tx_acked = ack;
      end
      REQ_OPEN: tx_sent = init_seq;
      REQ_SEND: begin
        if (tx_credit > 0) begin
          tx_sent = tx_sent + 32'd1;
          tx_credit = tx_credit - 1;
        end
      end
      REQ_ACK: begin
        if (ack - (tx_acked + 32'd1) < tx_sent - tx_acked + 32'd2) begin
          freed = ack - tx_acked;
          if (freed >= SEND_SLOTS - tx_credit) tx_credit = SEND_SLOTS;
          else tx_credit = tx_credit + freed;
          tx_acked = ack;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input int quota);
    int pick;
    int k;
    int j;
    int tmp;
    int offs [RECV_SLOTS];
    logic [31:0] span;
    logic [31:0] off;
    logic [2:0] t;
    send_idle = s_idle;
    recv_idle = r_idle;
    item_count = 0;
    while (item_count < quota) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        if (!rx_sync || $urandom_range(3) == 0) begin
          put_word(REQ_SYN, ($urandom_range(3) == 0) ? 32'hFFFF_FFF8 + $urandom_range(7)
                   : $urandom, $urandom, 16'($urandom_range(65535)));
          rx_sync = 1'b1;
        end
        k = $urandom_range(RECV_SLOTS, 1);
        for (int i = 0; i < k; i++) offs[i] = i;
        for (int i = k - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = offs[i];
          offs[i] = offs[j];
          offs[j] = tmp;
        end
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(9) == 0)
            put_word(REQ_DATA, rx_next + RECV_SLOTS + $urandom_range(100), $urandom,
                     16'($urandom_range(65535)));
          put_word(REQ_DATA, rx_next + offs[i], $urandom, 16'($urandom_range(65535)));
        end
        rx_next = rx_next + k;
      end else if (pick < 70) begin
        if ($urandom_range(3) == 0) begin
          put_word(REQ_OPEN, $urandom, $urandom, 16'($urandom_range(65535)));
          put_word(REQ_SYNACK, $urandom, tx_sent, 16'($urandom_range(65535)));
          rx_sync = 1'b1;
        end
        k = $urandom_range(10, 1);
        for (int i = 0; i < k; i++)
          put_word(REQ_SEND, $urandom, $urandom, 16'($urandom_range(65535)));
        k = $urandom_range(3);
        for (int i = 0; i < k; i++) begin
          span = tx_sent - tx_acked + 32'd2;
          if ($urandom_range(9) == 0 || span == 0) begin
            put_word(REQ_ACK, $urandom, tx_acked, 16'($urandom_range(65535)));
          end else begin
            off = ($urandom_range(3) != 0) ? $urandom_range((span > 10) ? 9 : span - 1)
                  : $urandom_range(span - 1);
            put_word(REQ_ACK, $urandom, tx_acked + 32'd1 + off,
                     16'($urandom_range(65535)));
          end
        end
      end else if (pick < 92) begin
        k = $urandom_range(3, 1);
        for (int i = 0; i < k; i++) begin
          t = 3'($urandom_range(7));
          put_word(t, $urandom, $urandom, 16'($urandom_range(65535)));
          if (t == REQ_DATA) rx_sync = 1'b0;
        end
      end else begin
        settle();
      end
    end
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_RESPONDER;
    cfg_data = '0;
    send_idle = 0;
    item_count = 0;
    rx_next = '0;
    tx_acked = '0;
    tx_sent = '0;
    tx_credit = SEND_SLOTS;
    rx_sync = 1'b1;
    resp_seq = RESPONDER_SEQ_RESET;
    init_seq = INITIATOR_SEQ_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFA);

    send_idle = 16;
    recv_idle = 50;
    // Open, then fill the send window across the wrap and overflow it.
    put_word(REQ_OPEN, '0, '0, '0);
    put_word(REQ_SYNACK, 32'hFFFF_FFFE, init_seq, 16'hFFFF);
    for (int i = 0; i < SEND_SLOTS + 1; i++)
      put_word(REQ_SEND, $urandom, $urandom, (i % 2) ? 16'h0000 : 16'hFFFF);
    // Stale ack, then the farthest ack the window takes.
    put_word(REQ_ACK, '0, tx_acked, '0);
    put_word(REQ_ACK, 32'hFFFF_FFFF, tx_sent + 32'd2, 16'hFFFF);
    // Buffer ahead, one just past the window, then the expected one drains both.
    put_word(REQ_DATA, 32'h0000_0000, '0, 16'hFFFF);
    put_word(REQ_DATA, 32'h0000_0007, 32'hFFFF_FFFF, 16'h1234);
    put_word(REQ_DATA, 32'hFFFF_FFFF, '0, 16'h0000);
    put_word(REQ_DATA, 32'h0000_0000, '0, 16'hABCD);
    put_word(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_word(3'd7, '0, '0, '0);
    put_word(REQ_SYN, 32'hFFFF_FFFF, '0, '0);
    rx_next = 32'd0;

    run_phase(16, 50, 170);
    write_regs(32'h0000_0000, $urandom);
    run_phase(50, 16, 170);
    write_regs($urandom, 32'h0000_0000);
    run_phase(0, 0, 170);

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
